### hw/rtl/klat_pkg.sv
package klat_pkg;

   localparam int DEF_STATION_SLOTS     = 64;
   localparam int DEF_LOADS_PER_STATION = 16;

   localparam int CFG_W    = 7;
   localparam int STN_W    = 6;
   localparam int SRC_W    = 7;
   localparam int KIND_W   = 8;
   localparam int ORIGIN_W = 6;
   localparam int AMT_W    = 32;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [ORIGIN_W-1:0]     origin;
      logic signed [AMT_W-1:0] amount;
   } entry_type;

endpackage

### hw/rtl/keyed_load_accumulator_table_unit.sv
// Per-station load table. A command is taken when start is high and busy is low; its one
// result appears on rsp_status/rsp_total for exactly one cycle with rsp_valid high and cannot
// be held off, so the receiver must take it then. A station at or above csr_count (or beyond
// the table) answers the cycle after acceptance with no further work. Otherwise the station's
// load count is read, then its loads are fetched from the entry memory one per cycle through
// its single read port and fed to one shared saturating adder; busy stays high until the
// result is issued (an add that hits an entry finishes early), and no new command is
// taken before then. After reset the load counts are swept to zero, one station per cycle,
// with busy held high for the sweep; csr writes are taken at any time.
module keyed_load_accumulator_table_unit #(
   parameter int STATION_SLOTS     = klat_pkg::DEF_STATION_SLOTS,
   parameter int LOADS_PER_STATION = klat_pkg::DEF_LOADS_PER_STATION
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [klat_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic [klat_pkg::STN_W-1:0]           req_station,
   input  logic [klat_pkg::KIND_W-1:0]          req_cargo_kind,
   input  logic signed [klat_pkg::SRC_W-1:0]    req_source_station,
   input  logic signed [klat_pkg::AMT_W-1:0]    req_delta,
   output logic                                 rsp_valid,
   output logic [klat_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [klat_pkg::AMT_W-1:0]    rsp_total
);
   import klat_pkg::*;

   localparam int CAW   = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;
   localparam int CW    = $clog2(LOADS_PER_STATION + 1);
   localparam int AW    = (STATION_SLOTS * LOADS_PER_STATION > 1) ?
                          $clog2(STATION_SLOTS * LOADS_PER_STATION) : 1;
   localparam int XW    = 11;
   localparam int ACC_W = AMT_W + CW + 1;

   localparam logic signed [ACC_W-1:0] SUM_MAX =
      {{(ACC_W-AMT_W+1){1'b0}}, {(AMT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SUM_MIN =
      {{(ACC_W-AMT_W+1){1'b1}}, {(AMT_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CFG_W-1:0] csr_count_ff;
   logic [CAW-1:0]   clr_ff, clr_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [CW-1:0]    chk_idx_ff, chk_idx_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic                    action_ff, action_in;
   logic [STN_W-1:0]        stn_ff, stn_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [ORIGIN_W-1:0]     origin_ff, origin_in;
   logic signed [AMT_W-1:0] delta_ff, delta_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic signed [AMT_W-1:0] rsp_total_ff, rsp_total_in;

   logic            accept;
   logic            bad_index;
   logic [XW-1:0]   req_stn_ext;
   logic [XW-1:0]   stn_ext;

   logic [CAW-1:0]  cnt_rd_addr;
   logic [CW-1:0]   cnt_rd_data;
   logic            cnt_wr_en;
   logic [CAW-1:0]  cnt_wr_addr;
   logic [CW-1:0]   cnt_wr_data;
   logic [AW-1:0]   ent_rd_addr;
   entry_type       ent_rd_data;
   logic            ent_wr_en;
   logic [AW-1:0]   ent_wr_addr;
   entry_type       ent_wr_data;
   logic [CW-1:0]   wr_idx;

   logic signed [ACC_W-1:0] add_a, add_b, add_sum;
   logic signed [AMT_W-1:0] sat_val;
   logic                    kind_match, entry_hit, scan_end;

   assign accept      = start && !busy;
   assign req_stn_ext = XW'(req_station);
   assign stn_ext     = XW'(stn_ff);
   assign bad_index   = (req_stn_ext >= XW'(csr_count_ff)) ||
                        (req_stn_ext >= XW'(STATION_SLOTS));

   assign cnt_rd_addr = req_stn_ext[CAW-1:0];
   assign ent_rd_addr = AW'(32'(stn_ff) * LOADS_PER_STATION + 32'(idx_ff));
   assign ent_wr_addr = AW'(32'(stn_ff) * LOADS_PER_STATION + 32'(wr_idx));

   // shared adder: delta + stored amount for an add, running sum + amount for a query
   assign add_a   = (action_ff == ACTION_QUERY) ? acc_ff : ACC_W'(delta_ff);
   assign add_b   = chk_vld_ff ? ACC_W'(ent_rd_data.amount) : '0;
   assign add_sum = add_a + add_b;

   always_comb begin
      priority if (add_sum > SUM_MAX) begin
         sat_val = SUM_MAX[AMT_W-1:0];
      end else if (add_sum < SUM_MIN) begin
         sat_val = SUM_MIN[AMT_W-1:0];
      end else begin
         sat_val = add_sum[AMT_W-1:0];
      end
   end

   assign kind_match = chk_vld_ff && (ent_rd_data.kind == kind_ff);
   assign entry_hit  = kind_match && (action_ff == ACTION_ADD) &&
                       (ent_rd_data.origin == origin_ff);
   assign scan_end   = !chk_vld_ff && (idx_ff == cnt_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      acc_in        = acc_ff;
      action_in     = action_ff;
      stn_in        = stn_ff;
      kind_in       = kind_ff;
      origin_in     = origin_ff;
      delta_in      = delta_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = stn_ext[CAW-1:0];
      cnt_wr_data   = cnt_ff + CW'(1);
      ent_wr_en     = 1'b0;
      wr_idx        = cnt_ff;
      ent_wr_data   = '{kind: kind_ff, origin: origin_ff, amount: delta_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            if (clr_ff == CAW'(STATION_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CAW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               action_in = req_action;
               stn_in    = req_station;
               kind_in   = req_cargo_kind;
               origin_in = req_source_station[SRC_W-1] ? req_station :
                           req_source_station[ORIGIN_W-1:0];
               delta_in  = req_delta;
               idx_in    = '0;
               acc_in    = '0;
               if (bad_index) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_BAD_INDEX;
                  rsp_total_in  = '0;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            cnt_in   = cnt_rd_data;
            state_in = ST_SCAN;
            // entry 0 is being fetched this cycle
            if (cnt_rd_data != '0) begin
               idx_in     = CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (kind_match && (action_ff == ACTION_QUERY)) begin
               acc_in = add_sum;
            end
            priority if (entry_hit) begin
               wr_idx             = chk_idx_ff;
               ent_wr_en          = 1'b1;
               ent_wr_data.kind   = ent_rd_data.kind;
               ent_wr_data.origin = ent_rd_data.origin;
               ent_wr_data.amount = sat_val;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_total_in       = '0;
               state_in           = ST_IDLE;
            end else if (scan_end) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (action_ff == ACTION_QUERY) begin
                  rsp_status_in = STATUS_OK;
                  rsp_total_in  = sat_val;
               end else if (cnt_ff == CW'(LOADS_PER_STATION)) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_total_in  = '0;
               end else begin
                  // append a new load at the end of the list
                  ent_wr_en     = 1'b1;
                  cnt_wr_en     = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_total_in  = '0;
               end
            end else begin
               if (idx_ff != cnt_ff) begin
                  idx_in     = idx_ff + CW'(1);
                  chk_vld_in = 1'b1;
                  chk_idx_in = idx_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         csr_count_ff <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      chk_idx_ff    <= chk_idx_in;
      acc_ff        <= acc_in;
      action_ff     <= action_in;
      stn_ff        <= stn_in;
      kind_ff       <= kind_in;
      origin_ff     <= origin_in;
      delta_ff      <= delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   klat_store #(
      .STATION_SLOTS     (STATION_SLOTS),
      .LOADS_PER_STATION (LOADS_PER_STATION)
   ) u_store (
      .clock       (clock),
      .cnt_rd_addr (cnt_rd_addr),
      .cnt_rd_data (cnt_rd_data),
      .cnt_wr_en   (cnt_wr_en),
      .cnt_wr_addr (cnt_wr_addr),
      .cnt_wr_data (cnt_wr_data),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_total  = rsp_total_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   a_bad_index_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && bad_index) |=> (rsp_valid && (rsp_status == STATUS_BAD_INDEX)))
      else $error("rejected station did not answer at once");

   a_good_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && !bad_index) |=> ((state_ff == ST_COUNT) && !rsp_valid))
      else $error("accepted command did not start the count read");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((idx_ff <= cnt_ff) && (cnt_ff <= CW'(LOADS_PER_STATION))))
      else $error("scan index ran past the load count");

endmodule

### hw/rtl/klat_store.sv
module klat_store #(
   parameter int  STATION_SLOTS     = klat_pkg::DEF_STATION_SLOTS,
   parameter int  LOADS_PER_STATION = klat_pkg::DEF_LOADS_PER_STATION,
   localparam int CAW = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1,
   localparam int CW  = $clog2(LOADS_PER_STATION + 1),
   localparam int AW  = (STATION_SLOTS * LOADS_PER_STATION > 1) ?
                        $clog2(STATION_SLOTS * LOADS_PER_STATION) : 1
) (
   input  logic                clock,
   input  logic [CAW-1:0]      cnt_rd_addr,
   output logic [CW-1:0]       cnt_rd_data,
   input  logic                cnt_wr_en,
   input  logic [CAW-1:0]      cnt_wr_addr,
   input  logic [CW-1:0]       cnt_wr_data,
   input  logic [AW-1:0]       ent_rd_addr,
   output klat_pkg::entry_type ent_rd_data,
   input  logic                ent_wr_en,
   input  logic [AW-1:0]       ent_wr_addr,
   input  klat_pkg::entry_type ent_wr_data
);
   import klat_pkg::*;

   localparam int ENTRY_DEPTH = STATION_SLOTS * LOADS_PER_STATION;

   logic [CW-1:0] count_mem [STATION_SLOTS];
   entry_type     entry_mem [ENTRY_DEPTH];
   logic [CW-1:0] cnt_rd_data_ff;
   entry_type     ent_rd_data_ff;

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         count_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      cnt_rd_data_ff <= count_mem[cnt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         entry_mem[ent_wr_addr] <= ent_wr_data;
      end
      ent_rd_data_ff <= entry_mem[ent_rd_addr];
   end

   assign cnt_rd_data = cnt_rd_data_ff;
   assign ent_rd_data = ent_rd_data_ff;

endmodule
